// ----- design/circle_pair_collision_response_defines.svh -----
// assertion macros for the circle pair collision response block
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_DEFINES_SVH

// same cycle implication
`define CPCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpcr: implication check failed");

// next cycle implication
`define CPCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cpcr: next cycle check failed");

`endif

// ----- design/cpcr_pkg.sv -----
// shared constants and helper functions for the collision response pipeline
// no dependencies
package cpcr_pkg;

  // pipelined divider geometry
  localparam int DIV_NUM_W = 60;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_STEPS = 28;

  // pipelined square root geometry
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_RAD_W = 2 * SQRT_STEPS;

  // register stages from input to output register
  localparam int PIPE_DEPTH = 2 + SQRT_STEPS + 3 + DIV_STEPS + 8 + DIV_STEPS + 4 + 1;

  localparam logic [23:0] SAT_MAX = 24'h7FFFFF;
  localparam logic [23:0] SAT_MIN = 24'h800000;

  // shift right by 16 with round to nearest, ties away from zero
  function automatic logic signed [31:0] rnd16(input logic signed [47:0] x);
    logic [47:0] mag;
    logic [47:0] q;
    mag = x[47] ? 48'(-x) : 48'(x);
    q = (mag + 48'h8000) >> 16;
    rnd16 = x[47] ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  // signed 24 bit saturation of a sign and magnitude quotient
  function automatic logic [23:0] sat_mag(input logic neg, input logic [DIV_STEPS-1:0] q);
    logic [23:0] r;
    if (!neg) begin
      r = (q > DIV_STEPS'(SAT_MAX)) ? SAT_MAX : q[23:0];
    end else begin
      r = (q > DIV_STEPS'(SAT_MIN)) ? SAT_MIN : (~q[23:0] + 24'd1);
    end
    return r;
  endfunction

  // signed 24 bit saturation of a 33 bit sum
  function automatic logic [23:0] sat33(input logic signed [32:0] x);
    logic [23:0] r;
    if (x > $signed(33'(SAT_MAX))) begin
      r = SAT_MAX;
    end else if (x < $signed({9'h1FF, SAT_MIN})) begin
      r = SAT_MIN;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

// ----- design/cpcr_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on cpcr_pkg for widths and stage count
module cpcr_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [cpcr_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [cpcr_pkg::DIV_DEN_W-1:0] den_i,
  output logic [cpcr_pkg::DIV_STEPS-1:0] quo_o
);
  import cpcr_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_STEPS-1:0] low_in;
    logic [DIV_STEPS-1:0] quo_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // stage inputs, the first stage takes the upper numerator bits
    if (k == 0) begin : g_first
      assign rem_in = DIV_DEN_W'(num_i[DIV_NUM_W-1:DIV_STEPS]);
      assign low_in = num_i[DIV_STEPS-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    // shift in one numerator bit and try the subtract
    assign trial = {rem_in, low_in[DIV_STEPS-1]};
    assign fits  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? DIV_DEN_W'(trial - {1'b0, den_in}) : trial[DIV_DEN_W-1:0];
        low_q[k] <= low_in << 1;
        quo_q[k] <= {quo_in[DIV_STEPS-2:0], fits};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

// ----- design/cpcr_sqrt.sv -----
// pipelined integer square root, one root bit per stage
// depends on cpcr_pkg for widths and stage count
module cpcr_sqrt (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [cpcr_pkg::SQRT_RAD_W-1:0] rad_i,
  output logic [cpcr_pkg::SQRT_STEPS-1:0] root_o
);
  import cpcr_pkg::*;

  localparam int RemW = SQRT_STEPS + 2;

  logic [RemW-1:0]       rem_q  [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] root_q [SQRT_STEPS];
  logic [SQRT_RAD_W-1:0] rad_q  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [RemW-1:0]       rem_in;
    logic [SQRT_STEPS-1:0] root_in;
    logic [SQRT_RAD_W-1:0] rad_in;
    logic [RemW+1:0]       cur;
    logic [RemW+1:0]       trial;
    logic                  fits;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down two radicand bits and test 4r + 1
    assign cur   = {rem_in, rad_in[SQRT_RAD_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign fits  = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? RemW'(cur - trial) : cur[RemW-1:0];
        root_q[k] <= {root_in[SQRT_STEPS-2:0], fits};
        rad_q[k]  <= rad_in << 2;
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];

endmodule

// ----- design/circle_pair_collision_response.sv -----
// Collision response for one pair of circles in Q15.8: separation shift and new
// velocities after a mass weighted elastic exchange along the center line, scaled
// by restitution. Fully pipelined: one pair is accepted every cycle unless the
// output stalls, and each result passes 106 register stages up to the output
// register. The depth comes from a 32 stage square root for the center distance
// and two 28 stage dividers in a row (unit direction and shift, then the
// exchanged speeds). When a finished result is not taken the whole pipeline
// holds, and in_ready_o drops.
// Depends on cpcr_pkg, cpcr_sqrt, cpcr_div and the assertion macro header.
`include "circle_pair_collision_response_defines.svh"

module circle_pair_collision_response (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] rel_pos_x_i,
  input  logic signed [23:0] rel_pos_y_i,
  input  logic signed [23:0] vel1_x_i,
  input  logic signed [23:0] vel1_y_i,
  input  logic signed [23:0] vel2_x_i,
  input  logic signed [23:0] vel2_y_i,
  input  logic [22:0]        radius_sum_i,
  input  logic [15:0]        mass1_i,
  input  logic [15:0]        mass2_i,
  input  logic [8:0]         restitution1_i,
  input  logic [8:0]         restitution2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] shift_x_o,
  output logic signed [23:0] shift_y_o,
  output logic signed [23:0] new_vel1_x_o,
  output logic signed [23:0] new_vel1_y_o,
  output logic signed [23:0] new_vel2_x_o,
  output logic signed [23:0] new_vel2_y_o,
  output logic               coincident_o
);
  import cpcr_pkg::*;

  typedef struct packed {
    logic signed [23:0] dx, dy, v1x, v1y, v2x, v2y;
    logic [22:0]        rs;
    logic [15:0]        m1, m2;
    logic [8:0]         e1, e2;
    logic [16:0]        msum;
    logic signed [16:0] mdiff;
    logic               coin;
    logic [46:0]        sqx, sqy;
    logic [47:0]        s;
    logic [31:0]        dq;
    logic signed [33:0] gap;
    logic signed [57:0] pgx, pgy;
    logic [23:0]        adx, ady;
    logic [59:0]        unx, uny, snx, sny;
    logic [32:0]        uden, sden;
    logic               sgx, sgy;
    logic signed [17:0] ux, uy;
    logic signed [23:0] sx, sy;
    logic signed [41:0] pv1x, pv1y, pv2x, pv2y;
    logic signed [42:0] sm1, sm2;
    logic signed [25:0] a1, a2;
    logic signed [43:0] pa, pb, pc, pd;
    logic signed [44:0] t1, t2;
    logic signed [54:0] n1, n2;
    logic [59:0]        nb1, nb2;
    logic [32:0]        bden;
    logic               sg1, sg2;
    logic signed [28:0] b1, b2;
    logic signed [29:0] db1, db2;
    logic signed [47:0] w1x, w1y, w2x, w2y;
    logic signed [31:0] r1x, r1y, r2x, r2y;
  } st_t;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;

  st_t s1_d, s1_q, s2_d, s2_q, s3_d, s3_q, s4_d, s4_q, s5_d, s5_q;
  st_t s6_d, s6_q, s7_d, s7_q, s8_d, s8_q, s9_d, s9_q, s10_d, s10_q;
  st_t s11_d, s11_q, s12_d, s12_q, s13_d, s13_q, s14_d, s14_q;
  st_t s15_d, s15_q, s16_d, s16_q, s17_d, s17_q;
  st_t sq_dly_q [SQRT_STEPS];
  st_t da_dly_q [DIV_STEPS];
  st_t db_dly_q [DIV_STEPS];

  logic [SQRT_STEPS-1:0] root;
  logic [DIV_STEPS-1:0]  q_ux, q_uy, q_sx, q_sy, q_b1, q_b2;

  logic signed [47:0] sq_x, sq_y;
  logic               mass_zero;
  logic [15:0]        m1_fix, m2_fix;
  logic signed [57:0] pgx_w, pgy_w;
  logic [57:0]        mgx, mgy;
  logic signed [41:0] pv1x_w, pv1y_w, pv2x_w, pv2y_w;
  logic signed [31:0] a1_w, a2_w;
  logic signed [43:0] pa_w, pb_w, pc_w, pd_w;
  logic signed [54:0] n1_w, n2_w;
  logic [54:0]        mn1, mn2;
  logic signed [47:0] w1x_w, w1y_w, w2x_w, w2y_w;
  logic signed [32:0] nv1x_w, nv1y_w, nv2x_w, nv2y_w;

  logic signed [23:0] shift_x_q, shift_y_q, nv1x_q, nv1y_q, nv2x_q, nv2y_q;
  logic               coin_q;

  // whole pipeline advances unless a finished word waits
  assign en         = !vld_q[PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // stage 1: squares, mass fixup
  assign sq_x      = rel_pos_x_i * rel_pos_x_i;
  assign sq_y      = rel_pos_y_i * rel_pos_y_i;
  assign mass_zero = (mass1_i == '0) && (mass2_i == '0);
  assign m1_fix    = mass_zero ? 16'd1 : mass1_i;
  assign m2_fix    = mass_zero ? 16'd1 : mass2_i;

  always_comb begin
    s1_d       = '0;
    s1_d.dx    = rel_pos_x_i;
    s1_d.dy    = rel_pos_y_i;
    s1_d.v1x   = vel1_x_i;
    s1_d.v1y   = vel1_y_i;
    s1_d.v2x   = vel2_x_i;
    s1_d.v2y   = vel2_y_i;
    s1_d.rs    = radius_sum_i;
    s1_d.m1    = m1_fix;
    s1_d.m2    = m2_fix;
    s1_d.e1    = restitution1_i;
    s1_d.e2    = restitution2_i;
    s1_d.msum  = {1'b0, m1_fix} + {1'b0, m2_fix};
    s1_d.mdiff = $signed({1'b0, m1_fix}) - $signed({1'b0, m2_fix});
    s1_d.sqx   = sq_x[46:0];
    s1_d.sqy   = sq_y[46:0];
  end

  // stage 2: squared distance
  always_comb begin
    s2_d      = s1_q;
    s2_d.s    = {1'b0, s1_q.sqx} + {1'b0, s1_q.sqy};
    s2_d.coin = (s2_d.s == '0);
  end

  // distance in unsigned Q16.16
  cpcr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({s2_q.s, 16'h0000}),
    .root_o (root)
  );

  // stage 3: gap to touching distance
  always_comb begin
    s3_d     = sq_dly_q[SQRT_STEPS-1];
    s3_d.dq  = root;
    s3_d.gap = $signed({2'b00, root}) - $signed({3'b000, s3_d.rs, 8'h00});
  end

  // stage 4: shift numerators, position magnitudes
  assign pgx_w = s3_q.gap * s3_q.dx;
  assign pgy_w = s3_q.gap * s3_q.dy;

  always_comb begin
    s4_d     = s3_q;
    s4_d.pgx = pgx_w;
    s4_d.pgy = pgy_w;
    s4_d.adx = s3_q.dx[23] ? 24'(-s3_q.dx) : 24'(s3_q.dx);
    s4_d.ady = s3_q.dy[23] ? 24'(-s3_q.dy) : 24'(s3_q.dy);
  end

  // stage 5: rounded divider operands
  assign mgx = s4_q.pgx[57] ? 58'(-s4_q.pgx) : 58'(s4_q.pgx);
  assign mgy = s4_q.pgy[57] ? 58'(-s4_q.pgy) : 58'(s4_q.pgy);

  always_comb begin
    s5_d      = s4_q;
    s5_d.unx  = {12'b0, s4_q.adx, 24'b0} + {29'b0, s4_q.dq[31:1]};
    s5_d.uny  = {12'b0, s4_q.ady, 24'b0} + {29'b0, s4_q.dq[31:1]};
    s5_d.snx  = {2'b00, mgx} + {28'b0, s4_q.dq};
    s5_d.sny  = {2'b00, mgy} + {28'b0, s4_q.dq};
    s5_d.uden = (s4_q.dq == '0) ? 33'd1 : {1'b0, s4_q.dq};
    s5_d.sden = (s4_q.dq == '0) ? 33'd1 : {s4_q.dq, 1'b0};
    s5_d.sgx  = s4_q.pgx[57];
    s5_d.sgy  = s4_q.pgy[57];
  end

  // unit direction and shift dividers
  cpcr_div u_div_ux (.clk_i(clk_i), .en_i(en), .num_i(s5_q.unx), .den_i(s5_q.uden),
                     .quo_o(q_ux));
  cpcr_div u_div_uy (.clk_i(clk_i), .en_i(en), .num_i(s5_q.uny), .den_i(s5_q.uden),
                     .quo_o(q_uy));
  cpcr_div u_div_sx (.clk_i(clk_i), .en_i(en), .num_i(s5_q.snx), .den_i(s5_q.sden),
                     .quo_o(q_sx));
  cpcr_div u_div_sy (.clk_i(clk_i), .en_i(en), .num_i(s5_q.sny), .den_i(s5_q.sden),
                     .quo_o(q_sy));

  // stage 6: signed direction, saturated shift
  always_comb begin
    s6_d    = da_dly_q[DIV_STEPS-1];
    s6_d.ux = s6_d.dx[23] ? -$signed({1'b0, q_ux[16:0]}) : $signed({1'b0, q_ux[16:0]});
    s6_d.uy = s6_d.dy[23] ? -$signed({1'b0, q_uy[16:0]}) : $signed({1'b0, q_uy[16:0]});
    s6_d.sx = sat_mag(s6_d.sgx, q_sx);
    s6_d.sy = sat_mag(s6_d.sgy, q_sy);
  end

  // stage 7: velocity projections
  assign pv1x_w = s6_q.ux * s6_q.v1x;
  assign pv1y_w = s6_q.uy * s6_q.v1y;
  assign pv2x_w = s6_q.ux * s6_q.v2x;
  assign pv2y_w = s6_q.uy * s6_q.v2y;

  always_comb begin
    s7_d      = s6_q;
    s7_d.pv1x = pv1x_w;
    s7_d.pv1y = pv1y_w;
    s7_d.pv2x = pv2x_w;
    s7_d.pv2y = pv2y_w;
  end

  // stage 8: dot products
  always_comb begin
    s8_d     = s7_q;
    s8_d.sm1 = s7_q.pv1x + s7_q.pv1y;
    s8_d.sm2 = s7_q.pv2x + s7_q.pv2y;
  end

  // stage 9: parallel speeds
  assign a1_w = rnd16(48'(s8_q.sm1));
  assign a2_w = rnd16(48'(s8_q.sm2));

  always_comb begin
    s9_d    = s8_q;
    s9_d.a1 = a1_w[25:0];
    s9_d.a2 = a2_w[25:0];
  end

  // stage 10: mass weighted terms
  assign pa_w = $signed({1'b0, s9_q.m2, 1'b0}) * s9_q.a2;
  assign pb_w = s9_q.mdiff * s9_q.a1;
  assign pc_w = $signed({1'b0, s9_q.m1, 1'b0}) * s9_q.a1;
  assign pd_w = s9_q.mdiff * s9_q.a2;

  always_comb begin
    s10_d    = s9_q;
    s10_d.pa = pa_w;
    s10_d.pb = pb_w;
    s10_d.pc = pc_w;
    s10_d.pd = pd_w;
  end

  // stage 11: exchange sums
  always_comb begin
    s11_d    = s10_q;
    s11_d.t1 = s10_q.pa + s10_q.pb;
    s11_d.t2 = s10_q.pc - s10_q.pd;
  end

  // stage 12: restitution scaling
  assign n1_w = s11_q.t1 * $signed({1'b0, s11_q.e2});
  assign n2_w = s11_q.t2 * $signed({1'b0, s11_q.e1});

  always_comb begin
    s12_d      = s11_q;
    s12_d.n1   = n1_w;
    s12_d.n2   = n2_w;
    s12_d.bden = {8'b0, s11_q.msum, 8'h00};
  end

  // stage 13: rounded exchange divider operands
  assign mn1 = s12_q.n1[54] ? 55'(-s12_q.n1) : 55'(s12_q.n1);
  assign mn2 = s12_q.n2[54] ? 55'(-s12_q.n2) : 55'(s12_q.n2);

  always_comb begin
    s13_d     = s12_q;
    s13_d.nb1 = {5'b0, mn1} + {28'b0, s12_q.bden[32:1]};
    s13_d.nb2 = {5'b0, mn2} + {28'b0, s12_q.bden[32:1]};
    s13_d.sg1 = s12_q.n1[54];
    s13_d.sg2 = s12_q.n2[54];
  end

  // exchanged speed dividers
  cpcr_div u_div_b1 (.clk_i(clk_i), .en_i(en), .num_i(s13_q.nb1), .den_i(s13_q.bden),
                     .quo_o(q_b1));
  cpcr_div u_div_b2 (.clk_i(clk_i), .en_i(en), .num_i(s13_q.nb2), .den_i(s13_q.bden),
                     .quo_o(q_b2));

  // stage 14: signed new parallel speeds
  always_comb begin
    s14_d    = db_dly_q[DIV_STEPS-1];
    s14_d.b1 = s14_d.sg1 ? -$signed({1'b0, q_b1}) : $signed({1'b0, q_b1});
    s14_d.b2 = s14_d.sg2 ? -$signed({1'b0, q_b2}) : $signed({1'b0, q_b2});
  end

  // stage 15: speed change along the center line
  always_comb begin
    s15_d     = s14_q;
    s15_d.db1 = s14_q.b1 - s14_q.a1;
    s15_d.db2 = s14_q.b2 - s14_q.a2;
  end

  // stage 16: change back onto the axes
  assign w1x_w = s15_q.db1 * s15_q.ux;
  assign w1y_w = s15_q.db1 * s15_q.uy;
  assign w2x_w = s15_q.db2 * s15_q.ux;
  assign w2y_w = s15_q.db2 * s15_q.uy;

  always_comb begin
    s16_d     = s15_q;
    s16_d.w1x = w1x_w;
    s16_d.w1y = w1y_w;
    s16_d.w2x = w2x_w;
    s16_d.w2y = w2y_w;
  end

  // stage 17: rounding
  always_comb begin
    s17_d     = s16_q;
    s17_d.r1x = rnd16(s16_q.w1x);
    s17_d.r1y = rnd16(s16_q.w1y);
    s17_d.r2x = rnd16(s16_q.w2x);
    s17_d.r2y = rnd16(s16_q.w2y);
  end

  // output stage: add, saturate, coincident override
  assign nv1x_w = s17_q.v1x + s17_q.r1x;
  assign nv1y_w = s17_q.v1y + s17_q.r1y;
  assign nv2x_w = s17_q.v2x + s17_q.r2x;
  assign nv2y_w = s17_q.v2y + s17_q.r2y;

  // payload registers and delay lines beside the sqrt and dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      s5_q  <= s5_d;
      s6_q  <= s6_d;
      s7_q  <= s7_d;
      s8_q  <= s8_d;
      s9_q  <= s9_d;
      s10_q <= s10_d;
      s11_q <= s11_d;
      s12_q <= s12_d;
      s13_q <= s13_d;
      s14_q <= s14_d;
      s15_q <= s15_d;
      s16_q <= s16_d;
      s17_q <= s17_d;
      sq_dly_q[0] <= s2_q;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq_dly_q[k] <= sq_dly_q[k-1];
      end
      da_dly_q[0] <= s5_q;
      db_dly_q[0] <= s13_q;
      for (int k = 1; k < DIV_STEPS; k++) begin
        da_dly_q[k] <= da_dly_q[k-1];
        db_dly_q[k] <= db_dly_q[k-1];
      end
      coin_q    <= s17_q.coin;
      shift_x_q <= s17_q.coin ? '0 : s17_q.sx;
      shift_y_q <= s17_q.coin ? '0 : s17_q.sy;
      nv1x_q    <= s17_q.coin ? s17_q.v1x : sat33(nv1x_w);
      nv1y_q    <= s17_q.coin ? s17_q.v1y : sat33(nv1y_w);
      nv2x_q    <= s17_q.coin ? s17_q.v2x : sat33(nv2x_w);
      nv2y_q    <= s17_q.coin ? s17_q.v2y : sat33(nv2y_w);
    end
  end

  assign out_valid_o  = vld_q[PIPE_DEPTH-1];
  assign shift_x_o    = shift_x_q;
  assign shift_y_o    = shift_y_q;
  assign new_vel1_x_o = nv1x_q;
  assign new_vel1_y_o = nv1y_q;
  assign new_vel2_x_o = nv2x_q;
  assign new_vel2_y_o = nv2y_q;
  assign coincident_o = coin_q;

  // checks
  `CPCR_ASSERT_IMP(a_coin_no_shift, out_valid_o && coincident_o, shift_x_o == '0 && shift_y_o == '0)
  `CPCR_ASSERT_NXT(a_stall_freezes, !in_ready_o, $stable(vld_q))
  `CPCR_ASSERT_NXT(a_accept_enters, in_valid_i && in_ready_o, vld_q[0])

endmodule

// ----- bench/circle_pair_collision_response_tb.sv -----
// testbench for circle_pair_collision_response: directed pairs then random pairs,
// each result word checked against a behavioral collision predictor in this file
// depends on the block's RTL only
module circle_pair_collision_response_tb;

  typedef struct packed {
    logic signed [23:0] dx;
    logic signed [23:0] dy;
    logic signed [23:0] v1x;
    logic signed [23:0] v1y;
    logic signed [23:0] v2x;
    logic signed [23:0] v2y;
    logic [22:0]        rsum;
    logic [15:0]        m1;
    logic [15:0]        m2;
    logic [8:0]         e1;
    logic [8:0]         e2;
  } pair_t;

  // result fields: 0 shift_x .. 5 new_vel2_y, 6 coincident in bit 0
  typedef logic [6:0][23:0] resp_t;

  typedef struct {
    pair_t p;
    bit    known;
    resp_t r;
  } row_t;

  localparam int NUM_RANDOM  = 1450;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pair_t cur = '0;
  resp_t got;

  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 70;
  int errors = 0;
  int words_checked = 0;
  int coincident_seen = 0;
  longint cycles = 0;
  resp_t resp_q[$];
  row_t  rows[$];

  circle_pair_collision_response dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rel_pos_x_i    (cur.dx),
    .rel_pos_y_i    (cur.dy),
    .vel1_x_i       (cur.v1x),
    .vel1_y_i       (cur.v1y),
    .vel2_x_i       (cur.v2x),
    .vel2_y_i       (cur.v2y),
    .radius_sum_i   (cur.rsum),
    .mass1_i        (cur.m1),
    .mass2_i        (cur.m2),
    .restitution1_i (cur.e1),
    .restitution2_i (cur.e2),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .shift_x_o      (got[0]),
    .shift_y_o      (got[1]),
    .new_vel1_x_o   (got[2]),
    .new_vel1_y_o   (got[3]),
    .new_vel2_x_o   (got[4]),
    .new_vel2_y_o   (got[5]),
    .coincident_o   (got[6][0])
  );
  assign got[6][23:1] = '0;

  always #4 clk_i = ~clk_i;

  // divide rounding to nearest, ties away from zero, den > 0
  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // collision response of one pair
  function automatic resp_t collide(pair_t p);
    resp_t r;
    longint dx, dy, v1x, v1y, v2x, v2y, rs, m1, m2, e1, e2;
    longint dlen, ux, uy, gap, msum, mdiff, a1, a2, b1, b2;
    longint unsigned sq;
    dx = p.dx; dy = p.dy;
    v1x = p.v1x; v1y = p.v1y; v2x = p.v2x; v2y = p.v2y;
    rs = longint'({1'b0, p.rsum});
    m1 = longint'({1'b0, p.m1}); m2 = longint'({1'b0, p.m2});
    e1 = longint'({1'b0, p.e1}); e2 = longint'({1'b0, p.e2});
    r = '0;
    sq = longint'(dx * dx) + longint'(dy * dy);
    if (sq == 0) begin
      // centers coincide: no shift, velocities pass through
      r[2] = p.v1x; r[3] = p.v1y; r[4] = p.v2x; r[5] = p.v2y;
      r[6] = 24'd1;
      return r;
    end
    dlen = longint'(root_floor(sq << 16));
    ux = div_round(dx * 16777216, dlen);
    uy = div_round(dy * 16777216, dlen);
    gap = dlen - rs * 256;
    r[0] = clamp24(div_round(gap * dx, 2 * dlen));
    r[1] = clamp24(div_round(gap * dy, 2 * dlen));
    if (m1 + m2 == 0) begin
      m1 = 1;
      m2 = 1;
    end
    msum = m1 + m2;
    mdiff = m1 - m2;
    a1 = div_round(ux * v1x + uy * v1y, 65536);
    a2 = div_round(ux * v2x + uy * v2y, 65536);
    b1 = div_round((2 * m2 * a2 + mdiff * a1) * e2, msum * 256);
    b2 = div_round((2 * m1 * a1 - mdiff * a2) * e1, msum * 256);
    r[2] = clamp24(v1x + div_round((b1 - a1) * ux, 65536));
    r[3] = clamp24(v1y + div_round((b1 - a1) * uy, 65536));
    r[4] = clamp24(v2x + div_round((b2 - a2) * ux, 65536));
    r[5] = clamp24(v2y + div_round((b2 - a2) * uy, 65536));
    return r;
  endfunction

  function automatic pair_t mk(int dx, int dy, int v1x, int v1y, int v2x, int v2y,
                               int rs, int m1, int m2, int e1, int e2);
    pair_t p;
    p.dx = 24'(dx); p.dy = 24'(dy);
    p.v1x = 24'(v1x); p.v1y = 24'(v1y); p.v2x = 24'(v2x); p.v2y = 24'(v2y);
    p.rsum = 23'(rs); p.m1 = 16'(m1); p.m2 = 16'(m2); p.e1 = 9'(e1); p.e2 = 9'(e2);
    return p;
  endfunction

  function automatic logic [23:0] rnd24(int unsigned span);
    logic [23:0] v;
    v = 24'($urandom_range(span));
    return $urandom_range(1) ? -v : v;
  endfunction

  // random pair: mostly circles of moderate size, some full-range noise, a few coincident
  function automatic pair_t rand_pair();
    pair_t p;
    int unsigned kind;
    kind = $urandom_range(99);
    p.dx = 24'($urandom); p.dy = 24'($urandom);
    p.v1x = 24'($urandom); p.v1y = 24'($urandom);
    p.v2x = 24'($urandom); p.v2y = 24'($urandom);
    p.rsum = 23'($urandom);
    p.m1 = 16'($urandom); p.m2 = 16'($urandom);
    p.e1 = 9'($urandom); p.e2 = 9'($urandom);
    if (kind < 70) begin
      p.dx = rnd24(20000); p.dy = rnd24(20000);
      p.v1x = rnd24(40000); p.v1y = rnd24(40000);
      p.v2x = rnd24(40000); p.v2y = rnd24(40000);
      p.rsum = 23'($urandom_range(30000));
      p.e1 = 9'($urandom_range(256)); p.e2 = 9'($urandom_range(256));
    end
    if (kind < 90 && p.m1 == 0 && p.m2 == 0) p.m1 = 16'd1;
    if (kind >= 95) begin
      p.dx = '0;
      p.dy = '0;
    end
    return p;
  endfunction

  task automatic send(pair_t p);
    @(negedge clk_i);
    cur = p;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    resp_q.push_back(collide(p));
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        want = resp_q.pop_front();
        words_checked++;
        if (got[6][0]) coincident_seen++;
        for (int i = 0; i < 7; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: field %0d expected %h actual %h", $time, i, want[i], got[i]);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t rw;
    int n;
    // directed rows: coincident ones have an obvious answer
    rw.known = 1'b1;
    rw.p = mk(0, 0, 1000, -2000, -3000, 4000, 512, 3, 5, 256, 256);
    rw.r = '0; rw.r[2] = 24'(1000); rw.r[3] = 24'(-2000);
    rw.r[4] = 24'(-3000); rw.r[5] = 24'(4000);
    rw.r[6] = 24'd1;
    rows.push_back(rw);
    rw.p = mk(0, 0, 8388607, -8388608, -8388608, 8388607, 8388607, 0, 0, 511, 511);
    rw.r = '0; rw.r[2] = 24'h7FFFFF; rw.r[3] = 24'h800000;
    rw.r[4] = 24'h800000; rw.r[5] = 24'h7FFFFF; rw.r[6] = 24'd1;
    rows.push_back(rw);
    rw.known = 1'b0;
    rw.r = '0;
    // head-on, equal masses, perfectly elastic
    rw.p = mk(256, 0, -512, 0, 512, 0, 512, 10, 10, 256, 256);               rows.push_back(rw);
    rw.p = mk(0, -300, 0, 700, 0, -700, 400, 1, 65535, 256, 256);           rows.push_back(rw);
    rw.p = mk(8388607, 8388607, 8388607, 8388607, -8388608, -8388608,
              8388607, 65535, 65535, 511, 511);                               rows.push_back(rw);
    rw.p = mk(-8388608, -8388608, -8388608, 8388607, 8388607, -8388608,
              0, 65535, 1, 0, 511);                                           rows.push_back(rw);
    // both masses zero, then one zero mass
    rw.p = mk(200, 150, 900, -100, -400, 300, 600, 0, 0, 256, 256);          rows.push_back(rw);
    rw.p = mk(200, 150, 900, -100, -400, 300, 600, 0, 77, 256, 200);         rows.push_back(rw);
    rw.p = mk(-100, 80, 300, 300, -300, -300, 300, 5, 9, 0, 0);              rows.push_back(rw);
    rw.p = mk(1, 0, 100, 100, -100, -100, 1, 2, 3, 128, 300);                rows.push_back(rw);
    rw.p = mk(0, 1, 8388607, 8388607, 8388607, 8388607, 8388607, 4, 4, 511, 1);
    rows.push_back(rw);
    // bodies apart: shift pulls them together
    rw.p = mk(10000, -20000, 50, 60, -70, 80, 0, 100, 200, 256, 256);        rows.push_back(rw);
    rw.p = mk(-1, -1, -1, -1, -1, -1, 1, 65535, 65534, 256, 255);            rows.push_back(rw);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (rows[i]) begin
      send(rows[i].p);
      if (rows[i].known) begin
        // replace the predicted word by the typed-in one
        void'(resp_q.pop_back());
        resp_q.push_back(rows[i].r);
      end
    end

    // random pairs over three idling phases
    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 36;
      end else if (n == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send(rand_pair());
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("checked %0d result words (%0d directed rows, %0d coincident pairs)",
             words_checked, rows.size(), coincident_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
